// ===== sv/fluid_cell_color_mapper_defines.svh =====
// Assertion macros shared by the pipeline control and hue modules.
`ifndef FLUID_CELL_COLOR_MAPPER_DEFINES_SVH
`define FLUID_CELL_COLOR_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define FCCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fccm check failed");
// Next-cycle implication, checked out of reset.
`define FCCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fccm check failed");
`else
`define FCCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/fccm_pkg.sv =====
// Types and constants of the fluid cell color mapper.
package fccm_pkg;

    // Pipeline depth and the place of each stage.
    localparam int NUM_STAGES = 9;
    localparam int ST_ABS     = 0;
    localparam int ST_QUOT    = 1;
    localparam int ST_HUE     = 2;
    localparam int ST_SECT    = 3;
    localparam int ST_CHAN    = 4;
    localparam int ST_PROD    = 5;
    localparam int ST_SCALE   = 6;
    localparam int ST_DIV     = 7;
    localparam int ST_OUT     = 8;

    // Field widths.
    localparam int DENS_W  = 24;
    localparam int VEL_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int CFG_W   = 9;
    localparam int IDX_W   = 2;
    localparam int MAG_W   = 16;
    localparam int QUOT_W  = 7;
    localparam int HUE_W   = 9;
    localparam int REM_W   = 6;
    localparam int VPROD_W = 37;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_COLOR_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_SATURATION = 2'd1;
    localparam logic [IDX_W-1:0] REG_VALUE      = 2'd2;

    // Arithmetic constants.
    localparam logic [15:0]       RECIP_360  = 16'd46604;   // ceil(2^24 / 360)
    localparam logic [14:0]       RECIP_60   = 15'd17477;   // ceil(2^20 / 60)
    localparam logic [HUE_W-1:0]  HUE_FULL   = 9'd360;
    localparam logic [REM_W-1:0]  HUE_SECT   = 6'd60;
    localparam logic [CFG_W-1:0]  FX_ONE     = 9'd256;
    localparam logic [14:0]       Q_FULL     = 15'd15360;   // 60 * 256
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
    localparam logic signed [VPROD_W-1:0] VEL_GAIN = 37'sd2550;
    localparam logic signed [VPROD_W-1:0] VEL_BIAS = 37'sd133693440; // 127.5 * 2^20

    typedef enum logic [1:0] {
        MODE_ALPHA = 2'd0,
        MODE_HUE   = 2'd1,
        MODE_VEL   = 2'd2
    } t_color_mode;

    typedef enum logic [2:0] {
        SECT_0 = 3'd0,
        SECT_1 = 3'd1,
        SECT_2 = 3'd2,
        SECT_3 = 3'd3,
        SECT_4 = 3'd4,
        SECT_5 = 3'd5
    } t_sector;

    // Load enables and valid bits of every stage.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

    // Per-item data that rides beside the hue path.
    typedef struct packed {
        logic [1:0]        mode;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] vel_r;
        logic [CHAN_W-1:0] vel_g;
    } t_side;

endpackage

// ===== sv/fccm_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the mapper pipeline.
`include "fluid_cell_color_mapper_defines.svh"

module fccm_pipe_ctrl import fccm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Valid bits advance with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready = w_en[0];
    assign o_ctl.en   = w_en;
    assign o_ctl.vld  = r_vld;

    `FCCM_ASSERT_NEXT(a_in_load, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])
    `FCCM_ASSERT_NEXT(a_first_hold, i_clk, i_rst_n, !o_in_ready, r_vld[0])
    `FCCM_ASSERT_NEXT(a_last_hold, i_clk, i_rst_n, r_vld[NUM_STAGES-1] && !i_out_ready, r_vld[NUM_STAGES-1])

endmodule

// ===== sv/fccm_hue.sv =====
// Density to hue sector and remainder: magnitude, divide by 360, wrap, split by 60.
`include "fluid_cell_color_mapper_defines.svh"

module fccm_hue import fccm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic [DENS_W-1:0] i_density,
    output t_sector           o_sector,
    output logic [REM_W-1:0]  o_rem
);

    logic [MAG_W-1:0]  r_mag0;
    logic              r_neg0;
    logic [MAG_W-1:0]  r_mag1;
    logic              r_neg1;
    logic [QUOT_W-1:0] r_quot1;
    logic [HUE_W-1:0]  r_hue2;
    t_sector           r_sector3;
    logic [REM_W-1:0]  r_rem3;

    logic [DENS_W-1:0] w_abs;
    logic [31:0]       w_qprod;
    logic [MAG_W-1:0]  w_sub;
    logic [HUE_W-1:0]  w_mod;
    logic [HUE_W-1:0]  w_hue;
    t_sector           w_sector;
    logic [HUE_W-1:0]  w_base;
    logic [HUE_W-1:0]  w_rem_full;

    // Integer part of the magnitude; the sign is kept for the wrap.
    assign w_abs = i_density[DENS_W-1] ? (~i_density + 24'd1) : i_density;

    // Quotient by 360 through a reciprocal, exact for the whole magnitude range.
    assign w_qprod = 32'(r_mag0) * 32'(RECIP_360);

    // Remainder by 360, folded into 0..359 for negative densities.
    assign w_sub = r_mag1 - 16'(r_quot1) * 16'(HUE_FULL);
    assign w_mod = w_sub[HUE_W-1:0];
    assign w_hue = (r_neg1 && (w_mod != '0)) ? HUE_FULL - w_mod : w_mod;

    // Sector of 60 degrees and the offset within it.
    always_comb begin
        if (r_hue2 >= 9'd300) begin
            w_sector = SECT_5;
            w_base   = 9'd300;
        end else if (r_hue2 >= 9'd240) begin
            w_sector = SECT_4;
            w_base   = 9'd240;
        end else if (r_hue2 >= 9'd180) begin
            w_sector = SECT_3;
            w_base   = 9'd180;
        end else if (r_hue2 >= 9'd120) begin
            w_sector = SECT_2;
            w_base   = 9'd120;
        end else if (r_hue2 >= 9'd60) begin
            w_sector = SECT_1;
            w_base   = 9'd60;
        end else begin
            w_sector = SECT_0;
            w_base   = 9'd0;
        end
    end
    assign w_rem_full = r_hue2 - w_base;

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_ABS]) begin
            r_mag0 <= w_abs[DENS_W-1:8];
            r_neg0 <= i_density[DENS_W-1];
        end
        if (i_ctl.en[ST_QUOT]) begin
            r_mag1  <= r_mag0;
            r_neg1  <= r_neg0;
            r_quot1 <= w_qprod[30:24];
        end
        if (i_ctl.en[ST_HUE]) begin
            r_hue2 <= w_hue;
        end
        if (i_ctl.en[ST_SECT]) begin
            r_sector3 <= w_sector;
            r_rem3    <= w_rem_full[REM_W-1:0];
        end
    end

    assign o_sector = r_sector3;
    assign o_rem    = r_rem3;

    `FCCM_ASSERT_IMPL(a_quot_low, i_clk, i_rst_n, i_ctl.vld[ST_QUOT], (17'(r_quot1) * 17'd360) <= 17'(r_mag1))
    `FCCM_ASSERT_IMPL(a_quot_high, i_clk, i_rst_n, i_ctl.vld[ST_QUOT], 17'(r_mag1) < (17'(r_quot1) * 17'd360 + 17'd360))
    `FCCM_ASSERT_IMPL(a_hue_range, i_clk, i_rst_n, i_ctl.vld[ST_HUE], r_hue2 < HUE_FULL)
    `FCCM_ASSERT_IMPL(a_rem_range, i_clk, i_rst_n, i_ctl.vld[ST_SECT], r_rem3 < HUE_SECT)

endmodule

// ===== sv/fccm_shade.sv =====
// HSV channel values from sector and remainder, four multiply stages and a sector select.
module fccm_shade import fccm_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  t_sector           i_sector,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [CFG_W-1:0]  i_saturation,
    input  logic [CFG_W-1:0]  i_value,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue
);

    logic [CFG_W-1:0]  w_s;
    logic [CFG_W-1:0]  w_v;
    logic [14:0]       w_sq;
    logic [14:0]       w_st;
    logic [14:0]       w_aq;
    logic [14:0]       w_at;
    logic [16:0]       w_vv;
    logic [16:0]       w_pn;
    logic [24:0]       w_pprod;
    logic [29:0]       w_zq;
    logic [29:0]       w_zt;
    logic [27:0]       w_dq;
    logic [27:0]       w_dt;

    t_sector           r_sect4, r_sect5, r_sect6, r_sect7;
    logic [CHAN_W-1:0] r_vv4, r_vv5, r_vv6, r_vv7;
    logic [13:0]       r_aq4, r_at4;
    logic [16:0]       r_pn4;
    logic [21:0]       r_yq5, r_yt5;
    logic [CHAN_W-1:0] r_p5, r_p6, r_p7;
    logic [13:0]       r_zq6, r_zt6;
    logic [CHAN_W-1:0] r_q7, r_t7;

    // Saturation and value above 1.0 count as 1.0.
    assign w_s = (i_saturation > FX_ONE) ? FX_ONE : i_saturation;
    assign w_v = (i_value > FX_ONE) ? FX_ONE : i_value;

    // Falling and rising ramps before scaling by value; full value and the floor term.
    assign w_sq = 15'(w_s) * 15'(i_rem);
    assign w_st = 15'(w_s) * 15'(HUE_SECT - i_rem);
    assign w_aq = Q_FULL - w_sq;
    assign w_at = Q_FULL - w_st;
    assign w_vv = 17'(w_v) * 17'(CHAN_MAX);
    assign w_pn = 17'(w_v) * 17'(FX_ONE - w_s);

    // Floor term scaled to 0..255.
    assign w_pprod = 25'(r_pn4) * 25'(CHAN_MAX);

    // Ramps scaled by 255 and reduced by 2^16.
    assign w_zq = 30'(r_yq5) * 30'(CHAN_MAX);
    assign w_zt = 30'(r_yt5) * 30'(CHAN_MAX);

    // Final divide by 60 through a reciprocal.
    assign w_dq = 28'(r_zq6) * 28'(RECIP_60);
    assign w_dt = 28'(r_zt6) * 28'(RECIP_60);

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_CHAN]) begin
            r_sect4 <= i_sector;
            r_aq4   <= w_aq[13:0];
            r_at4   <= w_at[13:0];
            r_vv4   <= w_vv[15:8];
            r_pn4   <= w_pn;
        end
        if (i_ctl.en[ST_PROD]) begin
            r_sect5 <= r_sect4;
            r_vv5   <= r_vv4;
            r_yq5   <= 22'(w_v) * 22'(r_aq4);
            r_yt5   <= 22'(w_v) * 22'(r_at4);
            r_p5    <= w_pprod[23:16];
        end
        if (i_ctl.en[ST_SCALE]) begin
            r_sect6 <= r_sect5;
            r_vv6   <= r_vv5;
            r_p6    <= r_p5;
            r_zq6   <= w_zq[29:16];
            r_zt6   <= w_zt[29:16];
        end
        if (i_ctl.en[ST_DIV]) begin
            r_sect7 <= r_sect6;
            r_vv7   <= r_vv6;
            r_p7    <= r_p6;
            r_q7    <= w_dq[27:20];
            r_t7    <= w_dt[27:20];
        end
    end

    // Channel order by sector.
    always_comb begin
        unique case (r_sect7)
            SECT_1: begin
                o_red = r_q7;  o_green = r_vv7; o_blue = r_p7;
            end
            SECT_2: begin
                o_red = r_p7;  o_green = r_vv7; o_blue = r_t7;
            end
            SECT_3: begin
                o_red = r_p7;  o_green = r_q7;  o_blue = r_vv7;
            end
            SECT_4: begin
                o_red = r_t7;  o_green = r_p7;  o_blue = r_vv7;
            end
            SECT_5: begin
                o_red = r_vv7; o_green = r_p7;  o_blue = r_q7;
            end
            default: begin
                o_red = r_vv7; o_green = r_t7;  o_blue = r_p7;
            end
        endcase
    end

endmodule

// ===== sv/fluid_cell_color_mapper.sv =====
// Top level of the fluid cell color mapper: registers, side path and output stage.
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  density, x_velocity, y_velocity
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  red, green, blue, alpha
//  cfg       in         i_cfg_valid/o_cfg_ready          register index, write data
//
// One cell enters per clock unless a receiver stall has filled the pipeline; pixels leave in order.
// The pipeline depth is set by the HSV path: reciprocal divide by 360, wrap, sector split and
// four multiply stages for the channel values.
// Every stage takes new data when it is empty or its content moves on, so bubbles close up
// under a stall and nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits and loads the register defaults.

module fluid_cell_color_mapper import fccm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [71:0]       i_s_axis_tdata,   // density[23:0], x_velocity[47:24], y_velocity[71:48]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [1:0]        r_color_mode;
    logic [CFG_W-1:0]  r_saturation;
    logic [CFG_W-1:0]  r_value;

    t_pipe_ctl         w_ctl;
    t_sector           w_sector;
    logic [REM_W-1:0]  w_rem;
    logic [CHAN_W-1:0] w_hsv_r, w_hsv_g, w_hsv_b;

    logic [DENS_W-1:0]         w_dens;
    logic signed [VEL_W-1:0]   w_vx;
    logic signed [VEL_W-1:0]   w_vy;
    logic [CHAN_W-1:0]         w_alpha;

    logic [1:0]                r_mode0;
    logic [CHAN_W-1:0]         r_alpha0;
    logic signed [VPROD_W-1:0] r_px0;
    logic signed [VPROD_W-1:0] r_py0;
    t_side                     r_side [ST_QUOT:ST_DIV];
    logic [31:0]               r_pix;

    // Velocity product to a channel byte: bias to mid scale, drop 20 fraction bits, clamp.
    function automatic logic [CHAN_W-1:0] vel_byte(input logic signed [VPROD_W-1:0] prod);
        logic signed [VPROD_W-1:0] num;
        logic [CHAN_W-1:0]         res;
        num = prod + VEL_BIAS;
        if (num[VPROD_W-1] || (num == '0)) begin
            res = '0;
        end else if (num[35:28] != '0) begin
            res = CHAN_MAX;
        end else begin
            res = num[27:20];
        end
        return res;
    endfunction

    // Configuration registers; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= MODE_ALPHA;
            r_saturation <= FX_ONE;
            r_value      <= FX_ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COLOR_MODE: r_color_mode <= i_cfg_data[1:0];
                REG_SATURATION: r_saturation <= i_cfg_data;
                REG_VALUE:      r_value      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fccm_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_ctl       (w_ctl)
    );

    assign w_dens = i_s_axis_tdata[23:0];
    assign w_vx   = i_s_axis_tdata[47:24];
    assign w_vy   = i_s_axis_tdata[71:48];

    fccm_hue u_hue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_density (w_dens),
        .o_sector  (w_sector),
        .o_rem     (w_rem)
    );

    fccm_shade u_shade (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_sector     (w_sector),
        .i_rem        (w_rem),
        .i_saturation (r_saturation),
        .i_value      (r_value),
        .o_red        (w_hsv_r),
        .o_green      (w_hsv_g),
        .o_blue       (w_hsv_b)
    );

    // Opacity from density: zero at or below zero, saturating at 255.
    always_comb begin
        if (w_dens[DENS_W-1]) begin
            w_alpha = '0;
        end else if (w_dens[22:16] != '0) begin
            w_alpha = CHAN_MAX;
        end else begin
            w_alpha = w_dens[15:8];
        end
    end

    // Side path: mode, opacity and velocity bytes travel beside the hue stages.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[ST_ABS]) begin
            r_mode0  <= r_color_mode;
            r_alpha0 <= w_alpha;
            r_px0    <= VPROD_W'(w_vx) * VEL_GAIN;
            r_py0    <= VPROD_W'(w_vy) * VEL_GAIN;
        end
        if (w_ctl.en[ST_QUOT]) begin
            r_side[ST_QUOT].mode  <= r_mode0;
            r_side[ST_QUOT].alpha <= r_alpha0;
            r_side[ST_QUOT].vel_r <= vel_byte(r_px0);
            r_side[ST_QUOT].vel_g <= vel_byte(r_py0);
        end
        for (int k = ST_HUE; k <= ST_DIV; k++) begin
            if (w_ctl.en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Output register: pick the pixel for the item's mode.
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[ST_OUT]) begin
            case (r_side[ST_DIV].mode)
                MODE_HUE: r_pix <= {CHAN_MAX, w_hsv_b, w_hsv_g, w_hsv_r};
                MODE_VEL: r_pix <= {CHAN_MAX, CHAN_MAX, r_side[ST_DIV].vel_g,
                                    r_side[ST_DIV].vel_r};
                default:  r_pix <= {r_side[ST_DIV].alpha, CHAN_MAX, CHAN_MAX, CHAN_MAX};
            endcase
        end
    end

    assign o_m_axis_tvalid = w_ctl.vld[ST_OUT];
    assign o_m_axis_tdata  = r_pix;

endmodule

// ===== tb/fluid_cell_color_mapper_test.sv =====
// Self-checking testbench for the fluid cell color mapper: directed table, then random cells.
`timescale 1ns / 100ps

module fluid_cell_color_mapper_test import fccm_pkg::*;;

    // Codes that the package leaves unnamed.
    localparam logic [1:0]       MODE_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNKNOWN = 2'd3;

    // Run shape.
    localparam int NUM_PHASES      = 14;
    localparam int CELLS_PER_PHASE = 50;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PRINT_LIMIT     = 40;
    localparam int SETTLE_CYCLES   = NUM_STAGES + 4;

    // Velocity mapping: 255 / 0.1 in Q4.20 steps, offset 127.5 in the same scale.
    localparam longint VEL_SCALE  = 2550;
    localparam longint VEL_OFFSET = 133693440;

    // One pixel, laid out like the result bus.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // One row of the directed table; want is alpha, blue, green, red from the top byte down.
    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] dens;
        logic [23:0] xvel;
        logic [23:0] yvel;
        logic        typed;
        logic [31:0] want;
    } t_cell_row;

    localparam int NUM_ROWS = 22;

    t_cell_row directed_rows [NUM_ROWS] = '{
        // Reset state: density as alpha over white.
        '{MODE_ALPHA, 24'h000000, 24'h7FFFFF, 24'h800000, 1'b1, 32'h00FFFFFF},
        '{MODE_ALPHA, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b1, 32'hFFFFFFFF},
        '{MODE_ALPHA, 24'h800000, 24'hFFFFFF, 24'h000000, 1'b1, 32'h00FFFFFF},
        '{MODE_ALPHA, 24'h000100, 24'h000000, 24'hFFFFFF, 1'b1, 32'h01FFFFFF},
        '{MODE_ALPHA, 24'h0000FF, 24'h555555, 24'hAAAAAA, 1'b1, 32'h00FFFFFF},
        '{MODE_ALPHA, 24'h010000, 24'hAAAAAA, 24'h555555, 1'b1, 32'hFFFFFFFF},
        // Density as hue, full saturation and value.
        '{MODE_HUE,   24'h000000, 24'h000000, 24'h000000, 1'b1, 32'hFF0000FF},
        '{MODE_HUE,   24'h003C00, 24'h000000, 24'h000000, 1'b1, 32'hFF00FFFF},
        '{MODE_HUE,   24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'hFFFF00, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h016800, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h7FFFFF, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h800000, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h007800, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h00B400, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h00F000, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h012C00, 24'h000000, 24'h000000, 1'b0, 32'h0},
        '{MODE_HUE,   24'h0167FF, 24'h000000, 24'h000000, 1'b0, 32'h0},
        // Velocity to red and green: both clamps, the midpoint and the edge of the range.
        '{MODE_VEL,   24'h000000, 24'h7FFFFF, 24'h800000, 1'b1, 32'hFFFF00FF},
        '{MODE_VEL,   24'h123456, 24'h000000, 24'h000000, 1'b1, 32'hFFFF7F7F},
        '{MODE_VEL,   24'h000000, 24'h00CCCD, 24'hFF3333, 1'b0, 32'h0},
        // The unused mode falls back to density as alpha.
        '{MODE_UNUSED, 24'h7FFFFF, 24'h000000, 24'h000000, 1'b1, 32'hFFFFFFFF}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [71:0]      i_s_axis_tdata;   // density[23:0], x_velocity[47:24], y_velocity[71:48]
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [31:0]      o_m_axis_tdata;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    // Register copies that the predictor works from.
    logic [1:0]       mode_reg;
    logic [CFG_W-1:0] sat_reg;
    logic [CFG_W-1:0] val_reg;

    t_pixel pending_pixels [$];
    int     mismatch_count;
    int     pixel_count;
    int     cycle_count;
    bit     steady_run;

    fluid_cell_color_mapper i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Print one mismatch line, up to a cap, and count every one.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // One velocity component mapped from -0.05..0.05 onto 0..255.
    function automatic logic [7:0] vel_level(input logic signed [23:0] vel);
        longint level;
        level = VEL_SCALE * longint'(vel) + VEL_OFFSET;
        if (level <= 0) begin
            return 8'd0;
        end
        level = level >>> 20;
        return (level > 255) ? 8'd255 : 8'(level);
    endfunction

    // Six-sector HSV conversion with the hue taken from the integer part of density.
    function automatic t_pixel hue_pixel(input logic signed [23:0] dens);
        longint mag, hue, sat, val, rem, vv, p, q, t;
        logic [2:0] sect;
        t_pixel px;
        mag = ((dens < 0) ? -longint'(dens) : longint'(dens)) >> 8;
        hue = mag % 360;
        // Negative hues wrap up into 0..359.
        if (dens < 0 && hue != 0) begin
            hue = 360 - hue;
        end
        sat  = (sat_reg > FX_ONE) ? 256 : longint'(sat_reg);
        val  = (val_reg > FX_ONE) ? 256 : longint'(val_reg);
        sect = 3'(hue / 60);
        rem  = hue % 60;
        vv = val * 255 / 256;
        p  = val * (256 - sat) * 255 / 65536;
        q  = val * (15360 - sat * rem) * 255 / 3932160;
        t  = val * (15360 - sat * (60 - rem)) * 255 / 3932160;
        px.alpha = 8'd255;
        case (sect)
            SECT_1: begin
                px.red = 8'(q);  px.green = 8'(vv); px.blue = 8'(p);
            end
            SECT_2: begin
                px.red = 8'(p);  px.green = 8'(vv); px.blue = 8'(t);
            end
            SECT_3: begin
                px.red = 8'(p);  px.green = 8'(q);  px.blue = 8'(vv);
            end
            SECT_4: begin
                px.red = 8'(t);  px.green = 8'(p);  px.blue = 8'(vv);
            end
            SECT_5: begin
                px.red = 8'(vv); px.green = 8'(p);  px.blue = 8'(q);
            end
            default: begin
                px.red = 8'(vv); px.green = 8'(t);  px.blue = 8'(p);
            end
        endcase
        return px;
    endfunction

    // Expected pixel for one cell under the current register copies.
    function automatic t_pixel paint_cell(input logic [71:0] cell_bits);
        logic signed [23:0] dens;
        t_pixel px;
        dens = cell_bits[23:0];
        case (mode_reg)
            MODE_HUE: begin
                px = hue_pixel(dens);
            end
            MODE_VEL: begin
                px.red   = vel_level(cell_bits[47:24]);
                px.green = vel_level(cell_bits[71:48]);
                px.blue  = CHAN_MAX;
                px.alpha = CHAN_MAX;
            end
            default: begin
                px.red   = CHAN_MAX;
                px.green = CHAN_MAX;
                px.blue  = CHAN_MAX;
                if (dens <= 0) begin
                    px.alpha = 8'd0;
                end else begin
                    px.alpha = (dens[23:8] > 16'd255) ? 8'd255 : dens[15:8];
                end
            end
        endcase
        return px;
    endfunction

    // Random idle decision for either side.
    function automatic bit idle_now();
        return !steady_run && ($urandom_range(99) < 23);
    endfunction

    // Offer one cell, with random gaps ahead of it; returns at the edge that takes it.
    task automatic push_cell(input logic [71:0] cell_bits, input bit typed, input t_pixel want);
        while (idle_now()) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= cell_bits;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_pixels.push_back(typed ? want : paint_cell(cell_bits));
    endtask

    // Stop sending and wait until every expected pixel is out and the pipeline is empty.
    task automatic drain_pipe();
        i_s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write request; the copy follows at the edge that takes it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_COLOR_MODE: mode_reg = data[1:0];
            REG_SATURATION: sat_reg  = data;
            REG_VALUE:      val_reg  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random cell, biased toward the interesting ranges of each mapping.
    function automatic logic [71:0] rand_cell();
        logic [23:0] dens, xvel, yvel;
        case ($urandom_range(3))
            0:       dens = 24'($urandom);
            1:       dens = 24'(int'($urandom_range(368640)) - 184320);
            2:       dens = 24'($urandom_range(24'h1FFFF));
            default: dens = 24'(-int'($urandom_range(24'h1FFFF)));
        endcase
        xvel = ($urandom_range(1) == 0) ? 24'($urandom) : 24'(int'($urandom_range(140000)) - 70000);
        yvel = ($urandom_range(1) == 0) ? 24'($urandom) : 24'(int'($urandom_range(140000)) - 70000);
        return {yvel, xvel, dens};
    endfunction

    // Receiver stalls.
    always @(posedge i_clk) begin
        i_m_axis_tready <= !idle_now();
    end

    // Compare each delivered pixel with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_pixel'(o_m_axis_tdata);
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %h", o_m_axis_tdata));
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red)
                    report_mismatch($sformatf("pixel %0d red %0d, want %0d",
                                              pixel_count, got.red, want.red));
                if (got.green !== want.green)
                    report_mismatch($sformatf("pixel %0d green %0d, want %0d",
                                              pixel_count, got.green, want.green));
                if (got.blue !== want.blue)
                    report_mismatch($sformatf("pixel %0d blue %0d, want %0d",
                                              pixel_count, got.blue, want.blue));
                if (got.alpha !== want.alpha)
                    report_mismatch($sformatf("pixel %0d alpha %0d, want %0d",
                                              pixel_count, got.alpha, want.alpha));
            end
            pixel_count++;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fluid_cell_color_mapper_test: errors");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, final drain.
    initial begin
        logic [CFG_W-1:0] sat_level, val_level;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        mode_reg        = MODE_ALPHA;
        sat_reg         = FX_ONE;
        val_reg         = FX_ONE;
        mismatch_count  = 0;
        pixel_count     = 0;
        cycle_count     = 0;
        steady_run      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; the mode register changes only between groups.
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (directed_rows[i].mode != mode_reg) begin
                drain_pipe();
                write_reg(REG_COLOR_MODE, CFG_W'(directed_rows[i].mode));
            end
            push_cell({directed_rows[i].yvel, directed_rows[i].xvel, directed_rows[i].dens},
                      directed_rows[i].typed, t_pixel'(directed_rows[i].want));
        end

        // A write to an unknown index must leave every register alone.
        drain_pipe();
        write_reg(REG_UNKNOWN, 9'h1FF);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipe();
            case (ph)
                1: begin
                    sat_level = 9'd0;   val_level = FX_ONE;
                end
                5: begin
                    sat_level = FX_ONE; val_level = 9'd0;
                end
                9: begin
                    sat_level = 9'h1FF; val_level = 9'h1FF;
                end
                default: begin
                    sat_level = CFG_W'($urandom_range(511));
                    val_level = CFG_W'($urandom_range(511));
                end
            endcase
            write_reg(REG_SATURATION, sat_level);
            write_reg(REG_VALUE, val_level);
            write_reg(REG_COLOR_MODE, CFG_W'(ph % 4));
            if (ph % 3 == 0) begin
                write_reg(REG_UNKNOWN, CFG_W'($urandom));
            end
            steady_run = (ph == 6);
            for (int n = 0; n < CELLS_PER_PHASE; n++) begin
                push_cell(rand_cell(), 1'b0, '0);
                // Hold the sender once mid-phase until the pipeline has emptied.
                if (ph == 3 && n == CELLS_PER_PHASE / 2) begin
                    drain_pipe();
                end
            end
            steady_run = 1'b0;
        end

        drain_pipe();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
        end
        if (mismatch_count == 0) begin
            $display("fluid_cell_color_mapper_test: clean");
        end else begin
            $display("fluid_cell_color_mapper_test: errors");
        end
        $finish;
    end

endmodule
